FILE: design/cfd_pkg.sv
// shared types, codes and crc helpers for the crc checked frame deframer
// no dependencies; used by cfd_cfg, cfd_parser and crc_checked_frame_deframer
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

	// width of the length field taken from bytes 1 and 2
	localparam int LENGTH_BITS = 12;
	localparam int POS_W       = 12;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// reflected polynomials
	localparam logic [7:0]  CRC8_POLY  = 8'h8C;
	localparam logic [15:0] CRC16_POLY = 16'h8408;

	// register reset values
	localparam logic [7:0]  START_BYTE_RST  = 8'hAA;
	localparam logic [11:0] FRAME_LIMIT_RST = 12'd4095;
	localparam logic [7:0]  HEADER_SEED_RST = 8'h77;
	localparam logic [15:0] BODY_SEED_RST   = 16'h3692;
	localparam logic [3:0]  VERSION_RST     = 4'd2;

	typedef enum logic [2:0] {
		PH_HUNT       = 3'd0,
		PH_LEN_LOW    = 3'd1,
		PH_LEN_HIGH   = 3'd2,
		PH_HDR_CHECK  = 3'd3,
		PH_BODY       = 3'd4,
		PH_SHORT_GOOD = 3'd5,
		PH_SHORT_BAD  = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_GOOD   = 3'd1,
		ST_LENVER = 3'd2,
		ST_HDR    = 3'd3,
		ST_BODY   = 3'd4,
		ST_SHORT  = 3'd5
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_BYTE       = 3'd0,
		REG_FRAME_LIMIT      = 3'd1,
		REG_HEADER_SEED      = 3'd2,
		REG_BODY_SEED        = 3'd3,
		REG_EXPECTED_VERSION = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  start_byte;
		logic [11:0] frame_limit;
		logic [7:0]  header_seed;
		logic [15:0] body_seed;
		logic [3:0]  expected_version;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       byte_value;
		logic             stored;
		logic [POS_W-1:0] position;
		status_t          status;
	} res_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: design/crc_checked_frame_deframer.sv
// top level of the crc checked frame deframer: input stage, parser and result register
// depends on cfd_pkg, cfd_cfg and cfd_parser
`timescale 1ns / 1ps
`default_nettype none

// byte-serial deframer. every received byte accepted on the input channel yields
// exactly one result transaction: the byte echoed, whether it was stored in the
// current frame, its frame position and a status code (0 busy or idle, 1 good
// frame, 2 bad length or version, 3 header crc error, 4 body crc error, 5 too
// short). a frame is start byte, 12-bit length (byte 1 plus low nibble of byte 2),
// version in the high nibble of byte 2, a reflected crc-8 over bytes 0..2 in
// byte 3, then the body closed by a reflected crc-16 (low byte first). the block
// takes one byte per clock and stays at that rate indefinitely as long as the
// output side keeps taking results; a result is offered once its byte has left
// the input register and the parser result has been caught in the result
// register. the one-byte-per-cycle figure is set by the parser state update,
// where the crc-8 and crc-16 byte steps are both combinational. while a
// result waits in the result register one more byte can still enter the
// input register; after that the input stalls until the result is taken.
// configuration registers are written through cfg_wr_en / cfg_index / cfg_data
// and must only be changed while no transaction is in flight; seeds are sampled
// at the start byte, limit and version at byte 2.
module crc_checked_frame_deframer (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write port
	input  wire logic                               cfg_wr_en,
	input  wire logic [cfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [cfd_pkg::CFG_DATA_W-1:0]     cfg_data,
	// received byte channel
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [7:0]                         rx_byte,
	// result channel
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [7:0]                              byte_value,
	output logic                                    stored,
	output logic [cfd_pkg::POS_W-1:0]               position,
	output logic [2:0]                              status
);

	cfd_pkg::cfg_t cfg;
	cfd_pkg::res_t res;
	cfd_pkg::res_t res_s2;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       valid_s2;
	logic       advance;

	cfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// a byte moves from the input register into the parser whenever the
	// result register is empty or is being drained in this cycle
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	cfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.byte_in (rx_byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign byte_value = res_s2.byte_value;
	assign stored     = res_s2.stored;
	assign position   = res_s2.position;
	assign status     = res_s2.status;

`ifndef SYNTHESIS
	// unstored bytes never carry a frame position
	a_unstored_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stored |-> position == '0)
		else $error("unstored byte with nonzero position");

	// a rejected length or version byte is never taken into the frame
	a_lenver_not_stored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cfd_pkg::ST_LENVER |-> !stored)
		else $error("length or version reject marked as stored");

	// every parser step lands in the result register
	a_step_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("parser step lost");

	// an empty input register always takes a transaction
	a_empty_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	// a byte held in the input register stays put while the result side stalls
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ready |=> valid_s1 && $stable(rx_byte_s1))
		else $error("input stage changed during stall");
`endif

endmodule

`default_nettype wire

FILE: design/cfd_cfg.sv
// configuration register file of the deframer
// depends on cfd_pkg for register indexes, reset values and cfg_t
`timescale 1ns / 1ps
`default_nettype none

module cfd_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [cfd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [cfd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output cfd_pkg::cfg_t                           cfg
);

	cfd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte       <= cfd_pkg::START_BYTE_RST;
			cfg_q.frame_limit      <= cfd_pkg::FRAME_LIMIT_RST;
			cfg_q.header_seed      <= cfd_pkg::HEADER_SEED_RST;
			cfg_q.body_seed        <= cfd_pkg::BODY_SEED_RST;
			cfg_q.expected_version <= cfd_pkg::VERSION_RST;
		end else if (cfg_wr_en) begin
			case (cfd_pkg::cfg_reg_t'(cfg_index))
				cfd_pkg::REG_START_BYTE:       cfg_q.start_byte       <= cfg_data[7:0];
				cfd_pkg::REG_FRAME_LIMIT:      cfg_q.frame_limit      <= cfg_data[11:0];
				cfd_pkg::REG_HEADER_SEED:      cfg_q.header_seed      <= cfg_data[7:0];
				cfd_pkg::REG_BODY_SEED:        cfg_q.body_seed        <= cfg_data[15:0];
				cfd_pkg::REG_EXPECTED_VERSION: cfg_q.expected_version <= cfg_data[3:0];
				default: begin
					// indexes past the list are dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: design/cfd_parser.sv
// frame parse state and per-byte decision logic with crc-8 / crc-16 updates
// depends on cfd_pkg for phase and status codes, cfg_t, res_t and crc functions
`timescale 1ns / 1ps
`default_nettype none

module cfd_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    byte_in,
	input  wire cfd_pkg::cfg_t cfg,
	output cfd_pkg::res_t      res
);

	localparam int PW = cfd_pkg::POS_W;
	localparam int LB = cfd_pkg::LENGTH_BITS;

	cfd_pkg::phase_t phase_q, phase_d;
	logic [PW-1:0]   count_q, count_d;
	logic [PW-1:0]   flen_q, flen_d;
	logic [7:0]      hcrc_q, hcrc_d;
	logic [15:0]     bcrc_q, bcrc_d;
	logic [7:0]      held_q, held_d;

	// length (byte 1 plus low nibble of byte 2) and version (high nibble of byte 2)
	logic [15:0]   len_raw;
	logic [LB-1:0] len_new;
	logic [15:0]   len_cmp;
	logic [PW-1:0] len_trunc;
	logic          lenver_bad;

	// body check shared by byte 2, byte 3 and the body bytes
	logic [PW-1:0] take_p;
	logic [PW-1:0] take_len;
	logic [PW:0]   take_p_ext;
	logic [PW:0]   take_len_ext;
	logic          take_mid;
	logic          take_held;
	logic          take_last;
	logic          take_ok;
	logic [15:0]   take_bcrc;
	logic [7:0]    take_held_val;

	assign len_raw    = {byte_in, flen_q[7:0]};
	assign len_new    = len_raw[LB-1:0];
	assign len_cmp    = 16'(len_new);
	assign len_trunc  = PW'(len_new);
	assign lenver_bad = (len_cmp > {4'h0, cfg.frame_limit})
		|| (byte_in[7:4] != cfg.expected_version);

	always_comb begin
		case (phase_q)
			cfd_pkg::PH_LEN_HIGH: begin
				take_p   = PW'(2);
				take_len = len_trunc;
			end
			cfd_pkg::PH_HDR_CHECK: begin
				take_p   = PW'(3);
				take_len = flen_q;
			end
			default: begin
				take_p   = count_q;
				take_len = flen_q;
			end
		endcase
	end

	assign take_p_ext    = {1'b0, take_p};
	assign take_len_ext  = {1'b0, take_len};
	assign take_mid      = (take_p_ext + (PW+1)'(2)) < take_len_ext;
	assign take_held     = (take_p_ext + (PW+1)'(2)) == take_len_ext;
	assign take_last     = (take_p_ext + (PW+1)'(1)) == take_len_ext;
	assign take_ok       = (bcrc_q[7:0] == held_q) && (bcrc_q[15:8] == byte_in);
	assign take_bcrc     = take_mid ? cfd_pkg::crc16_step(bcrc_q, byte_in) : bcrc_q;
	assign take_held_val = take_held ? byte_in : held_q;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		flen_d  = flen_q;
		hcrc_d  = hcrc_q;
		bcrc_d  = bcrc_q;
		held_d  = held_q;

		res.byte_value = byte_in;
		res.stored     = 1'b0;
		res.position   = '0;
		res.status     = cfd_pkg::ST_IDLE;

		case (phase_q)
			cfd_pkg::PH_HUNT: begin
				if (byte_in == cfg.start_byte) begin
					res.stored = 1'b1;
					count_d    = PW'(1);
					hcrc_d     = cfd_pkg::crc8_step(cfg.header_seed, byte_in);
					bcrc_d     = cfd_pkg::crc16_step(cfg.body_seed, byte_in);
					phase_d    = cfd_pkg::PH_LEN_LOW;
				end
			end
			cfd_pkg::PH_LEN_LOW: begin
				res.stored   = 1'b1;
				res.position = PW'(1);
				count_d      = PW'(2);
				flen_d       = PW'(byte_in);
				hcrc_d       = cfd_pkg::crc8_step(hcrc_q, byte_in);
				bcrc_d       = cfd_pkg::crc16_step(bcrc_q, byte_in);
				phase_d      = cfd_pkg::PH_LEN_HIGH;
			end
			cfd_pkg::PH_LEN_HIGH: begin
				if (lenver_bad) begin
					res.status = cfd_pkg::ST_LENVER;
					phase_d    = cfd_pkg::PH_HUNT;
				end else begin
					res.stored   = 1'b1;
					res.position = PW'(2);
					count_d      = PW'(3);
					flen_d       = len_trunc;
					hcrc_d       = cfd_pkg::crc8_step(hcrc_q, byte_in);
					// a verdict on byte 2 (length three) is dropped here
					bcrc_d       = take_bcrc;
					held_d       = take_held_val;
					phase_d      = cfd_pkg::PH_HDR_CHECK;
				end
			end
			cfd_pkg::PH_HDR_CHECK: begin
				res.stored   = 1'b1;
				res.position = PW'(3);
				count_d      = PW'(4);
				if (hcrc_q != byte_in) begin
					res.status = cfd_pkg::ST_HDR;
					phase_d    = cfd_pkg::PH_HUNT;
				end else begin
					bcrc_d = take_bcrc;
					held_d = take_held_val;
					if (take_last) begin
						phase_d = take_ok ? cfd_pkg::PH_SHORT_GOOD : cfd_pkg::PH_SHORT_BAD;
					end else begin
						phase_d = cfd_pkg::PH_BODY;
					end
				end
			end
			cfd_pkg::PH_BODY: begin
				if (count_q < flen_q) begin
					res.stored   = 1'b1;
					res.position = count_q;
					count_d      = count_q + PW'(1);
					bcrc_d       = take_bcrc;
					held_d       = take_held_val;
					if (take_last) begin
						res.status = take_ok ? cfd_pkg::ST_GOOD : cfd_pkg::ST_BODY;
						phase_d    = cfd_pkg::PH_HUNT;
					end
				end else begin
					res.status = cfd_pkg::ST_SHORT;
					phase_d    = cfd_pkg::PH_HUNT;
				end
			end
			cfd_pkg::PH_SHORT_GOOD: begin
				res.status = cfd_pkg::ST_GOOD;
				phase_d    = cfd_pkg::PH_HUNT;
			end
			cfd_pkg::PH_SHORT_BAD: begin
				res.status = cfd_pkg::ST_BODY;
				phase_d    = cfd_pkg::PH_HUNT;
			end
			default: begin
				phase_d = cfd_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfd_pkg::PH_HUNT;
			count_q <= '0;
			flen_q  <= '0;
			hcrc_q  <= '0;
			bcrc_q  <= '0;
			held_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			flen_q  <= flen_d;
			hcrc_q  <= hcrc_d;
			bcrc_q  <= bcrc_d;
			held_q  <= held_d;
		end
	end

endmodule

`default_nettype wire
